### src/asl_agc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asl_agc_pkg
// Shared widths, register indexes and controller/datapath types for the
// sound level AGC block.
// ----------------------------------------------------------------------------
package asl_agc_pkg;

   localparam int SAMPLE_BITS = 12;
   localparam int SAMPLE_W    = SAMPLE_BITS;
   localparam int LEVEL_W     = SAMPLE_BITS + 8;        // Q12.8 levels
   localparam int RATE_W      = 16;                     // Q0.16 rates
   localparam int CNT_W       = 16;
   localparam int NORM_W      = RATE_W + 1;             // Q0.16 level, 0..1.0
   localparam int PROD_W      = LEVEL_W + RATE_W;
   localparam int DIV_STEPS   = RATE_W;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
   localparam int CSR_IDX_W   = 4;
   localparam int CSR_DATA_W  = LEVEL_W;

   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX    = {SAMPLE_W{1'b1}};
   localparam logic [NORM_W-1:0]   ONE_Q16       = NORM_W'(1) << RATE_W;
   localparam logic [PROD_W-1:0]   ROUND_HALF    = PROD_W'(1) << (RATE_W - 1);
   localparam logic [LEVEL_W-1:0]  INIT_FLOOR    = '0;
   localparam logic [LEVEL_W-1:0]  INIT_ENVELOPE = LEVEL_W'(12800);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SAMPLES  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_NOISE_GATE      = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_FLOOR_FALL_RATE = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_FLOOR_RISE_RATE = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_ATTACK_RATE     = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE_RATE    = CSR_IDX_W'(5);
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_ENVELOPE    = CSR_IDX_W'(6);
   localparam logic [CSR_IDX_W-1:0] CSR_SMOOTHING_RATE  = CSR_IDX_W'(7);

   // register reset values
   localparam logic [CNT_W-1:0]   RST_WINDOW_SAMPLES  = CNT_W'(1024);
   localparam logic [LEVEL_W-1:0] RST_NOISE_GATE      = LEVEL_W'(2560);
   localparam logic [RATE_W-1:0]  RST_FLOOR_FALL_RATE = RATE_W'(6554);
   localparam logic [RATE_W-1:0]  RST_FLOOR_RISE_RATE = RATE_W'(66);
   localparam logic [RATE_W-1:0]  RST_ATTACK_RATE     = RATE_W'(19661);
   localparam logic [RATE_W-1:0]  RST_RELEASE_RATE    = RATE_W'(328);
   localparam logic [LEVEL_W-1:0] RST_MIN_ENVELOPE    = LEVEL_W'(12800);
   localparam logic [RATE_W-1:0]  RST_SMOOTHING_RATE  = RATE_W'(16384);

   // which tracker the shared multiplier serves
   typedef enum logic [1:0] {
      MUL_FLOOR = 2'd0,
      MUL_ENV   = 2'd1,
      MUL_LVL   = 2'd2
   } mul_sel_type;

   typedef struct packed {
      logic        track;      // sample transfer: update window min/max/count
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        floor_upd;
      logic        sig_upd;
      logic        env_upd;
      logic        div_init;
      logic        div_step;
      logic        lvl_upd;
      logic        load_out;
   } dp_cmd_type;

   typedef struct packed {
      logic window_end;        // current sample closes the window
      logic div_sat;           // signal >= envelope, level saturates at 1.0
      logic div_last;          // final quotient bit this cycle
   } dp_status_type;

endpackage

### src/asl_agc_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asl_agc_req_if
// Sample input channel: valid/ready with one converter sample.
// ----------------------------------------------------------------------------
interface asl_agc_req_if;
   logic                               valid;
   logic                               ready;
   logic [asl_agc_pkg::SAMPLE_W-1:0]   sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

### src/asl_agc_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asl_agc_rsp_if
// Per-window result channel: valid/ready with the AGC measurements.
// ----------------------------------------------------------------------------
interface asl_agc_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [asl_agc_pkg::SAMPLE_W-1:0]   peak_to_peak;
   logic [asl_agc_pkg::LEVEL_W-1:0]    noise_floor;
   logic [asl_agc_pkg::LEVEL_W-1:0]    envelope_max;
   logic [asl_agc_pkg::NORM_W-1:0]     level;

   modport source (output valid, output peak_to_peak, output noise_floor,
                   output envelope_max, output level, input ready);
   modport sink   (input valid, input peak_to_peak, input noise_floor,
                   input envelope_max, input level, output ready);
endinterface

### src/asl_agc_csr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asl_agc_csr_if
// Register write channel: valid/ready with register index and write data.
// ----------------------------------------------------------------------------
interface asl_agc_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [asl_agc_pkg::CSR_IDX_W-1:0]    index;
   logic [asl_agc_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### src/asl_agc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asl_agc_dp
// Datapath: registers, window min/max tracking, shared rate multiplier,
// floor/envelope/level trackers, restoring divider and result register.
// ----------------------------------------------------------------------------
module asl_agc_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  asl_agc_pkg::dp_cmd_type             cmd,
   output asl_agc_pkg::dp_status_type          status,
   input  logic [asl_agc_pkg::SAMPLE_W-1:0]    sample,
   input  logic                                csr_we,
   input  logic [asl_agc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [asl_agc_pkg::CSR_DATA_W-1:0]  csr_data,
   output logic [asl_agc_pkg::SAMPLE_W-1:0]    out_peak_to_peak,
   output logic [asl_agc_pkg::LEVEL_W-1:0]     out_noise_floor,
   output logic [asl_agc_pkg::LEVEL_W-1:0]     out_envelope_max,
   output logic [asl_agc_pkg::NORM_W-1:0]      out_level
);

   // configuration
   logic [asl_agc_pkg::CNT_W-1:0]   window_samples_ff;
   logic [asl_agc_pkg::LEVEL_W-1:0] noise_gate_ff;
   logic [asl_agc_pkg::RATE_W-1:0]  floor_fall_rate_ff;
   logic [asl_agc_pkg::RATE_W-1:0]  floor_rise_rate_ff;
   logic [asl_agc_pkg::RATE_W-1:0]  attack_rate_ff;
   logic [asl_agc_pkg::RATE_W-1:0]  release_rate_ff;
   logic [asl_agc_pkg::LEVEL_W-1:0] min_envelope_ff;
   logic [asl_agc_pkg::RATE_W-1:0]  smoothing_rate_ff;

   // window tracking
   logic [asl_agc_pkg::SAMPLE_W-1:0] win_min_ff, win_min_in;
   logic [asl_agc_pkg::SAMPLE_W-1:0] win_max_ff, win_max_in;
   logic [asl_agc_pkg::CNT_W-1:0]    win_cnt_ff, win_cnt_in;
   logic [asl_agc_pkg::SAMPLE_W-1:0] pp_ff;

   // tracker state
   logic [asl_agc_pkg::LEVEL_W-1:0]  floor_ff, floor_in;
   logic [asl_agc_pkg::LEVEL_W-1:0]  env_ff, env_in;
   logic [asl_agc_pkg::NORM_W-1:0]   level_ff, level_in;
   logic [asl_agc_pkg::LEVEL_W-1:0]  sig_ff, sig_in;

   // multiplier
   logic [asl_agc_pkg::LEVEL_W-1:0]  mul_a;
   logic [asl_agc_pkg::RATE_W-1:0]   mul_b;
   logic                             mul_sub;
   logic [asl_agc_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic                             sub_ff;
   logic [asl_agc_pkg::PROD_W-1:0]   prod_rnd;
   logic [asl_agc_pkg::LEVEL_W-1:0]  step;

   // divider
   logic [asl_agc_pkg::LEVEL_W-1:0]   rem_ff, rem_in;
   logic [asl_agc_pkg::NORM_W-1:0]    raw_ff, raw_in;
   logic [asl_agc_pkg::DIV_CNT_W-1:0] div_cnt_ff;
   logic [asl_agc_pkg::LEVEL_W:0]     rem_sh;
   logic [asl_agc_pkg::LEVEL_W:0]     rem_sub;
   logic                              quo_bit;

   // result register
   logic [asl_agc_pkg::SAMPLE_W-1:0] res_pp_ff;
   logic [asl_agc_pkg::LEVEL_W-1:0]  res_floor_ff;
   logic [asl_agc_pkg::LEVEL_W-1:0]  res_env_ff;
   logic [asl_agc_pkg::NORM_W-1:0]   res_level_ff;

   logic [asl_agc_pkg::LEVEL_W-1:0]  pp_q;
   logic [asl_agc_pkg::LEVEL_W:0]    gate_sum;
   logic [asl_agc_pkg::LEVEL_W:0]    sig_diff;
   logic [asl_agc_pkg::LEVEL_W-1:0]  env_step;
   logic [asl_agc_pkg::LEVEL_W-1:0]  env_floor;
   logic [asl_agc_pkg::LEVEL_W-1:0]  lvl_ext;
   logic [asl_agc_pkg::LEVEL_W-1:0]  lvl_step;
   logic [asl_agc_pkg::LEVEL_W-1:0]  raw_ext;

   logic [asl_agc_pkg::SAMPLE_W-1:0] samp_min, samp_max;
   logic [asl_agc_pkg::CNT_W-1:0]    cnt_inc;

   // ---------------- window min/max ----------------
   assign samp_min = (sample < win_min_ff) ? sample : win_min_ff;
   assign samp_max = (sample > win_max_ff) ? sample : win_max_ff;
   assign cnt_inc  = win_cnt_ff + asl_agc_pkg::CNT_W'(1);

   assign status.window_end = (cnt_inc == '0) || (cnt_inc >= window_samples_ff);

   always_comb begin
      win_min_in = win_min_ff;
      win_max_in = win_max_ff;
      win_cnt_in = win_cnt_ff;
      if (cmd.track) begin
         if (status.window_end) begin
            win_min_in = asl_agc_pkg::SAMPLE_MAX;
            win_max_in = '0;
            win_cnt_in = '0;
         end else begin
            win_min_in = samp_min;
            win_max_in = samp_max;
            win_cnt_in = cnt_inc;
         end
      end
   end

   // ---------------- shared rate multiplier ----------------
   assign pp_q    = {pp_ff, 8'b0};
   assign lvl_ext = asl_agc_pkg::LEVEL_W'(level_ff);
   assign raw_ext = asl_agc_pkg::LEVEL_W'(raw_ff);

   always_comb begin
      mul_a   = '0;
      mul_b   = '0;
      mul_sub = 1'b0;
      case (cmd.mul_sel)
         asl_agc_pkg::MUL_FLOOR: begin
            if (pp_q < floor_ff) begin
               mul_sub = 1'b1;
               mul_a   = floor_ff - pp_q;
               mul_b   = floor_fall_rate_ff;
            end else begin
               mul_a   = pp_q - floor_ff;
               mul_b   = floor_rise_rate_ff;
            end
         end
         asl_agc_pkg::MUL_ENV: begin
            if (sig_ff > env_ff) begin
               mul_a   = sig_ff - env_ff;
               mul_b   = attack_rate_ff;
            end else begin
               mul_sub = 1'b1;
               mul_a   = env_ff - sig_ff;
               mul_b   = release_rate_ff;
            end
         end
         asl_agc_pkg::MUL_LVL: begin
            if (raw_ext >= lvl_ext) begin
               mul_a   = raw_ext - lvl_ext;
               mul_b   = smoothing_rate_ff;
            end else begin
               mul_sub = 1'b1;
               mul_a   = lvl_ext - raw_ext;
               mul_b   = smoothing_rate_ff;
            end
         end
         default: begin
            mul_a   = '0;
            mul_b   = '0;
            mul_sub = 1'b0;
         end
      endcase
   end

   assign prod_in  = mul_a * mul_b;
   // round half up, magnitude never exceeds the difference
   assign prod_rnd = prod_ff + asl_agc_pkg::ROUND_HALF;
   assign step     = prod_rnd[asl_agc_pkg::PROD_W-1:asl_agc_pkg::RATE_W];

   // ---------------- trackers ----------------
   assign floor_in = sub_ff ? (floor_ff - step) : (floor_ff + step);

   assign gate_sum = {1'b0, floor_ff} + {1'b0, noise_gate_ff};
   assign sig_diff = {1'b0, pp_q} - gate_sum;
   assign sig_in   = ({1'b0, pp_q} > gate_sum) ?
                     sig_diff[asl_agc_pkg::LEVEL_W-1:0] : '0;

   assign env_step  = sub_ff ? (env_ff - step) : (env_ff + step);
   assign env_floor = (min_envelope_ff == '0) ? asl_agc_pkg::LEVEL_W'(1) : min_envelope_ff;
   assign env_in    = (env_step < env_floor) ? env_floor : env_step;

   assign lvl_step = sub_ff ? (lvl_ext - step) : (lvl_ext + step);
   assign level_in = (lvl_step > asl_agc_pkg::LEVEL_W'(asl_agc_pkg::ONE_Q16)) ?
                     asl_agc_pkg::ONE_Q16 : lvl_step[asl_agc_pkg::NORM_W-1:0];

   // ---------------- restoring divider: (sig << 16) / env ----------------
   assign status.div_sat  = (sig_ff >= env_ff);
   assign status.div_last = (div_cnt_ff == asl_agc_pkg::DIV_CNT_W'(asl_agc_pkg::DIV_STEPS - 1));

   assign rem_sh  = {rem_ff, 1'b0};
   assign rem_sub = rem_sh - {1'b0, env_ff};
   assign quo_bit = (rem_sh >= {1'b0, env_ff});

   always_comb begin
      rem_in = rem_ff;
      raw_in = raw_ff;
      if (cmd.div_init) begin
         rem_in = sig_ff;
         raw_in = status.div_sat ? asl_agc_pkg::ONE_Q16 : '0;
      end else if (cmd.div_step) begin
         rem_in = quo_bit ? rem_sub[asl_agc_pkg::LEVEL_W-1:0]
                          : rem_sh[asl_agc_pkg::LEVEL_W-1:0];
         raw_in = {1'b0, raw_ff[asl_agc_pkg::RATE_W-2:0], quo_bit};
      end
   end

   assign out_peak_to_peak = res_pp_ff;
   assign out_noise_floor  = res_floor_ff;
   assign out_envelope_max = res_env_ff;
   assign out_level        = res_level_ff;

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         window_samples_ff  <= asl_agc_pkg::RST_WINDOW_SAMPLES;
         noise_gate_ff      <= asl_agc_pkg::RST_NOISE_GATE;
         floor_fall_rate_ff <= asl_agc_pkg::RST_FLOOR_FALL_RATE;
         floor_rise_rate_ff <= asl_agc_pkg::RST_FLOOR_RISE_RATE;
         attack_rate_ff     <= asl_agc_pkg::RST_ATTACK_RATE;
         release_rate_ff    <= asl_agc_pkg::RST_RELEASE_RATE;
         min_envelope_ff    <= asl_agc_pkg::RST_MIN_ENVELOPE;
         smoothing_rate_ff  <= asl_agc_pkg::RST_SMOOTHING_RATE;
      end else if (csr_we) begin
         case (csr_index)
            asl_agc_pkg::CSR_WINDOW_SAMPLES:
               window_samples_ff <= csr_data[asl_agc_pkg::CNT_W-1:0];
            asl_agc_pkg::CSR_NOISE_GATE:      noise_gate_ff <= csr_data;
            asl_agc_pkg::CSR_FLOOR_FALL_RATE:
               floor_fall_rate_ff <= csr_data[asl_agc_pkg::RATE_W-1:0];
            asl_agc_pkg::CSR_FLOOR_RISE_RATE:
               floor_rise_rate_ff <= csr_data[asl_agc_pkg::RATE_W-1:0];
            asl_agc_pkg::CSR_ATTACK_RATE:
               attack_rate_ff <= csr_data[asl_agc_pkg::RATE_W-1:0];
            asl_agc_pkg::CSR_RELEASE_RATE:
               release_rate_ff <= csr_data[asl_agc_pkg::RATE_W-1:0];
            asl_agc_pkg::CSR_MIN_ENVELOPE:    min_envelope_ff <= csr_data;
            asl_agc_pkg::CSR_SMOOTHING_RATE:
               smoothing_rate_ff <= csr_data[asl_agc_pkg::RATE_W-1:0];
            default: ;   // unknown index: write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_min_ff <= asl_agc_pkg::SAMPLE_MAX;
         win_max_ff <= '0;
         win_cnt_ff <= '0;
         floor_ff   <= asl_agc_pkg::INIT_FLOOR;
         env_ff     <= asl_agc_pkg::INIT_ENVELOPE;
         level_ff   <= '0;
      end else begin
         win_min_ff <= win_min_in;
         win_max_ff <= win_max_in;
         win_cnt_ff <= win_cnt_in;
         if (cmd.floor_upd) floor_ff <= floor_in;
         if (cmd.env_upd)   env_ff   <= env_in;
         if (cmd.lvl_upd)   level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.track && status.window_end) pp_ff <= samp_max - samp_min;
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
         sub_ff  <= mul_sub;
      end
      if (cmd.sig_upd) sig_ff <= sig_in;
      rem_ff <= rem_in;
      raw_ff <= raw_in;
      if (cmd.div_init)      div_cnt_ff <= '0;
      else if (cmd.div_step) div_cnt_ff <= div_cnt_ff + asl_agc_pkg::DIV_CNT_W'(1);
      if (cmd.load_out) begin
         res_pp_ff    <= pp_ff;
         res_floor_ff <= floor_ff;
         res_env_ff   <= env_ff;
         res_level_ff <= level_ff;
      end
   end

   // ---------------- checks ----------------
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      level_ff <= asl_agc_pkg::ONE_Q16)
      else $error("smoothed level above 1.0");

   a_env_nonzero: assert property (@(posedge clock) disable iff (reset)
      env_ff != '0)
      else $error("envelope reached zero");

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> (rem_ff < env_ff))
      else $error("divider remainder not below divisor");

endmodule

### src/asl_agc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asl_agc_ctrl
// Sequencer: takes samples, then walks the per-window update through the
// shared multiplier and divider, and owns the result valid flag.
// ----------------------------------------------------------------------------
module asl_agc_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output asl_agc_pkg::dp_cmd_type       cmd,
   input  asl_agc_pkg::dp_status_type    status
);

   typedef enum logic [10:0] {
      S_COLLECT   = 11'b000_0000_0001,
      S_FLOOR_MUL = 11'b000_0000_0010,
      S_FLOOR_UPD = 11'b000_0000_0100,
      S_SIG       = 11'b000_0000_1000,
      S_ENV_MUL   = 11'b000_0001_0000,
      S_ENV_UPD   = 11'b000_0010_0000,
      S_DIV_INIT  = 11'b000_0100_0000,
      S_DIV       = 11'b000_1000_0000,
      S_LVL_MUL   = 11'b001_0000_0000,
      S_LVL_UPD   = 11'b010_0000_0000,
      S_OUT       = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_COLLECT);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_COLLECT: begin
            cmd.track = req_valid;
            if (req_valid && status.window_end) state_in = S_FLOOR_MUL;
         end
         S_FLOOR_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = asl_agc_pkg::MUL_FLOOR;
            state_in    = S_FLOOR_UPD;
         end
         S_FLOOR_UPD: begin
            cmd.floor_upd = 1'b1;
            state_in      = S_SIG;
         end
         S_SIG: begin
            cmd.sig_upd = 1'b1;
            state_in    = S_ENV_MUL;
         end
         S_ENV_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = asl_agc_pkg::MUL_ENV;
            state_in    = S_ENV_UPD;
         end
         S_ENV_UPD: begin
            cmd.env_upd = 1'b1;
            state_in    = S_DIV_INIT;
         end
         S_DIV_INIT: begin
            cmd.div_init = 1'b1;
            state_in     = status.div_sat ? S_LVL_MUL : S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = S_LVL_MUL;
         end
         S_LVL_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = asl_agc_pkg::MUL_LVL;
            state_in    = S_LVL_UPD;
         end
         S_LVL_UPD: begin
            cmd.lvl_upd = 1'b1;
            state_in    = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_COLLECT;
            end
         end
         default: state_in = S_COLLECT;
      endcase
   end

   always_comb begin
      if (cmd.load_out)     rsp_valid_in = 1'b1;
      else if (rsp_ready)   rsp_valid_in = 1'b0;
      else                  rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_COLLECT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------- checks ----------------
   a_block_after_end: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && status.window_end) |=> !req_ready)
      else $error("sample taken while window update pending");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == S_OUT))
      else $error("result raised outside the output step");

   a_div_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && status.div_last) |=> (state_ff == S_LVL_MUL))
      else $error("divider did not hand over to level update");

endmodule

### src/adaptive_sound_level_agc_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_sound_level_agc_top
// Peak-to-peak sound level meter with noise floor tracking and envelope AGC.
// ----------------------------------------------------------------------------
// Usage:
//   req: one unsigned converter sample per transfer. While a window is being
//        collected the block takes one sample every cycle.
//   rsp: one result per finished window: peak-to-peak in counts, noise floor and
//        envelope (Q12.8) and the smoothed level (Q0.16, 65536 = 1.0).
//   csr: register writes, always ready; write only while the block is idle.
// Update: after the transfer of the sample that closes a window,
//   req.ready stays low while the update runs through the shared multiplier
//   and a 16-step restoring divider (one quotient bit per cycle), which is
//   skipped when the level saturates at 1.0. rsp.valid is registered and
//   rises once the output step has loaded the result register.
// Stalls: the result sits in an output register; if it is still untaken
//   when the next window finishes, the sequencer holds in its output step
//   and sample input stays blocked until rsp.ready frees the register.
// Reset (synchronous): registers to defaults, window cleared, floor 0,
//   envelope 50.0 counts, level 0, no result pending.
// ----------------------------------------------------------------------------
module adaptive_sound_level_agc_top (
   input  logic           clock,
   input  logic           reset,
   asl_agc_req_if.sink    req,
   asl_agc_rsp_if.source  rsp,
   asl_agc_csr_if.sink    csr
);

   asl_agc_pkg::dp_cmd_type    cmd;
   asl_agc_pkg::dp_status_type status;
   logic                       req_ready;
   logic                       rsp_valid;

   assign req.ready = req_ready;
   assign rsp.valid = rsp_valid;
   assign csr.ready = 1'b1;

   asl_agc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd),
      .status    (status)
   );

   asl_agc_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .sample           (req.sample),
      .csr_we           (csr.valid),
      .csr_index        (csr.index),
      .csr_data         (csr.data),
      .out_peak_to_peak (rsp.peak_to_peak),
      .out_noise_floor  (rsp.noise_floor),
      .out_envelope_max (rsp.envelope_max),
      .out_level        (rsp.level)
   );

endmodule
